[design/cmg_pkg.sv]
// Shared types, constants and month tables for the month-grid cell pipeline.
package cmg_pkg;

    localparam int unsigned YEAR_W   = 14;
    localparam int unsigned MONTH_W  = 4;
    localparam int unsigned ROW_W    = 3;
    localparam int unsigned COL_W    = 3;
    localparam int unsigned DAY_W    = 5;
    localparam int unsigned WDAY_W   = 3;
    localparam int unsigned Q100_W   = 7;
    localparam int unsigned PROD_W   = 27;
    localparam int unsigned RECIP_SH = 19;

    localparam logic [YEAR_W-1:0]  YEAR_MIN     = 14'd1;
    localparam logic [YEAR_W-1:0]  YEAR_MAX     = 14'd9999;
    localparam logic [YEAR_W-1:0]  SWITCH_YEAR  = 14'd1752;
    localparam logic [MONTH_W-1:0] SWITCH_MONTH = 4'd8;
    localparam logic [MONTH_W-1:0] MONTH_FEB    = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_MAX    = 4'd11;
    localparam logic [ROW_W-1:0]   ROW_MAX      = 3'd5;
    localparam logic [COL_W-1:0]   COL_MAX      = 3'd6;
    localparam logic [DAY_W-1:0]   SWITCH_LEN   = 5'd19;
    // floor(y * RECIP_100 / 2^19) == floor(y / 100) across the whole year range
    localparam logic [PROD_W-1:0]  RECIP_100    = 27'd5243;
    localparam logic [YEAR_W-1:0]  CENTURY      = 14'd100;

    // Front stage result: clamped date plus the shifted year and century quotients
    typedef struct packed {
        logic [YEAR_W-1:0]  yr;
        logic [MONTH_W-1:0] mo;
        logic [YEAR_W-1:0]  y;
        logic [MONTH_W-1:0] m;
        logic [Q100_W-1:0]  q_y;
        logic [Q100_W-1:0]  q_yr;
        logic               greg;
        logic               sw;
    } t_front;

    // Sum stage result: weekday sum before the mod 7 and the month length
    typedef struct packed {
        logic [YEAR_W-1:0] sum;
        logic [DAY_W-1:0]  len;
        logic              sw;
    } t_sums;

    function automatic logic [DAY_W-1:0] base_length(input logic [MONTH_W-1:0] mo);
        logic [DAY_W-1:0] len;
        case (mo)
            4'd1:                       len = 5'd28;
            4'd3, 4'd5, 4'd8, 4'd10:    len = 5'd30;
            default:                    len = 5'd31;
        endcase
        return len;
    endfunction

    // floor(31 * m / 12) for the March-based month index m = 1..12
    function automatic logic [DAY_W-1:0] month_offset(input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] t;
        case (m)
            4'd1:    t = 5'd2;
            4'd2:    t = 5'd5;
            4'd3:    t = 5'd7;
            4'd4:    t = 5'd10;
            4'd5:    t = 5'd12;
            4'd6:    t = 5'd15;
            4'd7:    t = 5'd18;
            4'd8:    t = 5'd20;
            4'd9:    t = 5'd23;
            4'd10:   t = 5'd25;
            4'd11:   t = 5'd28;
            4'd12:   t = 5'd31;
            default: t = 5'd0;
        endcase
        return t;
    endfunction

endpackage

[design/cmg_front.sv]
// Front stage: clamp the date, shift the year to March-based, divide by 100.
module cmg_front import cmg_pkg::*; (
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    output t_front             o_front
);

    logic [YEAR_W-1:0]  yr;
    logic [MONTH_W-1:0] mo;
    logic               early;
    logic [YEAR_W-1:0]  y;
    logic [PROD_W-1:0]  prod_y;
    logic [PROD_W-1:0]  prod_yr;

    always_comb begin
        if (i_year < YEAR_MIN) begin
            yr = YEAR_MIN;
        end else if (i_year > YEAR_MAX) begin
            yr = YEAR_MAX;
        end else begin
            yr = i_year;
        end
        mo = (i_month > MONTH_MAX) ? MONTH_MAX : i_month;
    end

    // January and February count as months 11 and 12 of the previous year
    assign early   = (mo <= MONTH_FEB);
    assign y       = yr - YEAR_W'(early);
    assign prod_y  = PROD_W'(y) * RECIP_100;
    assign prod_yr = PROD_W'(yr) * RECIP_100;

    always_comb begin
        o_front.yr   = yr;
        o_front.mo   = mo;
        o_front.y    = y;
        o_front.m    = early ? (mo + 4'd11) : (mo - 4'd1);
        o_front.q_y  = prod_y[RECIP_SH +: Q100_W];
        o_front.q_yr = prod_yr[RECIP_SH +: Q100_W];
        o_front.greg = (y > SWITCH_YEAR) || ((yr == SWITCH_YEAR) && (mo > SWITCH_MONTH));
        o_front.sw   = (yr == SWITCH_YEAR) && (mo == SWITCH_MONTH);
    end

endmodule

[design/cmg_sum.sv]
// Sum stage: weekday congruence sum and month length with the leap rule.
module cmg_sum import cmg_pkg::*; (
    input  t_front i_front,
    output t_sums  o_sums
);

    logic              leap;
    logic [YEAR_W-1:0] cent;
    logic [YEAR_W-1:0] base;
    logic [DAY_W-1:0]  len;

    assign cent = YEAR_W'(i_front.q_yr) * CENTURY;

    // Julian rule up to the switch year, Gregorian century rule after
    assign leap = (i_front.yr[1:0] == 2'b00)
               && ((i_front.yr <= SWITCH_YEAR) || (i_front.yr != cent)
                   || (i_front.q_yr[1:0] == 2'b00));

    assign base = i_front.y + (i_front.y >> 2) + YEAR_W'(month_offset(i_front.m));

    always_comb begin
        len = base_length(i_front.mo);
        if (i_front.sw) begin
            len = SWITCH_LEN;
        end else if (i_front.mo == MONTH_FEB && leap) begin
            len = len + 5'd1;
        end
    end

    always_comb begin
        if (i_front.greg) begin
            o_sums.sum = base + 14'd1 - YEAR_W'(i_front.q_y) + YEAR_W'(i_front.q_y >> 2);
        end else begin
            o_sums.sum = base + 14'd6;
        end
        o_sums.len = len;
        o_sums.sw  = i_front.sw;
    end

endmodule

[design/cmg_mod7.sv]
// Mod 7 of the weekday sum by folding octal digits (8 is 1 mod 7).
module cmg_mod7 import cmg_pkg::*; (
    input  logic [YEAR_W-1:0] i_sum,
    output logic [WDAY_W-1:0] o_wday
);

    logic [4:0] fold1;
    logic [3:0] fold2;

    assign fold1 = 5'(i_sum[2:0]) + 5'(i_sum[5:3]) + 5'(i_sum[8:6])
                 + 5'(i_sum[11:9]) + 5'(i_sum[13:12]);
    assign fold2 = 4'(fold1[2:0]) + 4'(fold1[4:3]);
    assign o_wday = (fold2 >= 4'd7) ? 3'(fold2 - 4'd7) : fold2[2:0];

endmodule

[design/cmg_cell.sv]
// Cell stage: day number shown at a grid row and column, blank as zero.
module cmg_cell import cmg_pkg::*; (
    input  logic [WDAY_W-1:0] i_first,
    input  logic [DAY_W-1:0]  i_len,
    input  logic              i_sw,
    input  logic [ROW_W-1:0]  i_row,
    input  logic [COL_W-1:0]  i_column,
    output logic [DAY_W-1:0]  o_day
);

    logic [5:0] k;
    logic [5:0] pos;
    logic [5:0] n;
    logic       in_grid;

    assign k       = 6'(i_row) * 6'd7 + 6'(i_column);
    assign pos     = k + 6'd1;
    assign n       = pos - 6'(i_first);
    assign in_grid = (i_row <= ROW_MAX) && (i_column <= COL_MAX);

    always_comb begin
        o_day = '0;
        if (in_grid) begin
            if (i_sw) begin
                // switch-over month: 1, 2, then skip straight to the 14th
                if (k == 6'd2) begin
                    o_day = 5'd1;
                end else if (k == 6'd3) begin
                    o_day = 5'd2;
                end else if (k >= 6'd4 && k <= 6'd20) begin
                    o_day = 5'(k + 6'd10);
                end
            end else if (pos > 6'(i_first) && n <= 6'(i_len)) begin
                o_day = n[DAY_W-1:0];
            end
        end
    end

endmodule

[design/calendar_month_grid_cell.sv]
// Month-grid cell of a perpetual calendar: five-stage pipeline top level.
// Each accepted transaction passes through every stage; its results are marked by o_valid.
// Throughput: one transaction per cycle; busy stays low, so start is always taken.
// The stages are input register, date front end, weekday sum, mod 7, cell select.
// Reset (i_rst_n, synchronous, active low) clears all stage valid flags.
// Results are presented for one cycle only; the receiver cannot stall.
module calendar_month_grid_cell import cmg_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [YEAR_W-1:0]  i_year,
    input  logic [MONTH_W-1:0] i_month,
    input  logic [ROW_W-1:0]   i_row,
    input  logic [COL_W-1:0]   i_column,
    output logic               o_valid,
    output logic [DAY_W-1:0]   o_day_number,
    output logic [WDAY_W-1:0]  o_first_weekday,
    output logic [DAY_W-1:0]   o_month_length
);

    logic               r_a_valid;
    logic [YEAR_W-1:0]  r_a_year;
    logic [MONTH_W-1:0] r_a_month;
    logic [ROW_W-1:0]   r_a_row;
    logic [COL_W-1:0]   r_a_col;

    logic               r_b_valid;
    t_front             r_b_front;
    logic [ROW_W-1:0]   r_b_row;
    logic [COL_W-1:0]   r_b_col;

    logic               r_c_valid;
    t_sums              r_c_sums;
    logic [ROW_W-1:0]   r_c_row;
    logic [COL_W-1:0]   r_c_col;

    logic               r_d_valid;
    logic [WDAY_W-1:0]  r_d_first;
    logic [DAY_W-1:0]   r_d_len;
    logic               r_d_sw;
    logic [ROW_W-1:0]   r_d_row;
    logic [COL_W-1:0]   r_d_col;

    logic               r_valid;
    logic [DAY_W-1:0]   r_day;
    logic [WDAY_W-1:0]  r_first;
    logic [DAY_W-1:0]   r_len;

    t_front             n_front;
    t_sums              n_sums;
    logic [WDAY_W-1:0]  n_first;
    logic [DAY_W-1:0]   n_day;

    assign busy = 1'b0;

    cmg_front u_front (
        .i_year  (r_a_year),
        .i_month (r_a_month),
        .o_front (n_front)
    );

    cmg_sum u_sum (
        .i_front (r_b_front),
        .o_sums  (n_sums)
    );

    cmg_mod7 u_mod7 (
        .i_sum  (r_c_sums.sum),
        .o_wday (n_first)
    );

    cmg_cell u_cell (
        .i_first  (r_d_first),
        .i_len    (r_d_len),
        .i_sw     (r_d_sw),
        .i_row    (r_d_row),
        .i_column (r_d_col),
        .o_day    (n_day)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_a_valid <= start && !busy;
            r_b_valid <= r_a_valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
            r_valid   <= r_d_valid;
        end
    end

    // payload advances every cycle; the valid chain marks live transactions
    always_ff @(posedge i_clk) begin
        r_a_year  <= i_year;
        r_a_month <= i_month;
        r_a_row   <= i_row;
        r_a_col   <= i_column;

        r_b_front <= n_front;
        r_b_row   <= r_a_row;
        r_b_col   <= r_a_col;

        r_c_sums  <= n_sums;
        r_c_row   <= r_b_row;
        r_c_col   <= r_b_col;

        r_d_first <= n_first;
        r_d_len   <= r_c_sums.len;
        r_d_sw    <= r_c_sums.sw;
        r_d_row   <= r_c_row;
        r_d_col   <= r_c_col;

        r_day     <= n_day;
        r_first   <= r_d_first;
        r_len     <= r_d_len;
    end

    assign o_valid         = r_valid;
    assign o_day_number    = r_day;
    assign o_first_weekday = r_first;
    assign o_month_length  = r_len;

`ifndef NO_ASSERTIONS
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_valid)
        else $error("accepted transaction did not reach the output");

    a_weekday: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_first_weekday <= 3'd6))
        else $error("first weekday out of range");

    a_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_month_length >= SWITCH_LEN && o_month_length <= 5'd31))
        else $error("month length out of range");

    a_day_fits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_month_length != SWITCH_LEN) |-> (o_day_number <= o_month_length))
        else $error("day number beyond month length");
`endif

endmodule

[bench/calendar_month_grid_cell_tb.sv]
// Self-checking testbench for the month-grid cell of the perpetual calendar.
`timescale 1ns / 100ps

module calendar_month_grid_cell_tb;
    import cmg_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 100000;
    localparam int unsigned ITEMS_PER_RUN = 200;
    localparam int unsigned MAX_REPORTS   = 10;
    localparam int unsigned SETTLE_CYCLES = 8;
    localparam int unsigned MONTH_DAYS [12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [ROW_W-1:0]   row;
        logic [COL_W-1:0]   column;
    } t_cell_req;

    typedef struct packed {
        logic [DAY_W-1:0]  day;
        logic [WDAY_W-1:0] first_wd;
        logic [DAY_W-1:0]  len;
    } t_cell_view;

    typedef struct packed {
        t_cell_req  req;
        logic       typed;
        t_cell_view want;
    } t_grid_row;

    localparam int unsigned N_DIRECTED = 24;
    localparam t_grid_row GRID_TABLE [N_DIRECTED] = '{
        // switch-over month, values read straight off the layout
        '{'{14'd1752, 4'd8, 3'd0, 3'd0}, 1'b1, '{5'd0, 3'd2, 5'd19}},
        '{'{14'd1752, 4'd8, 3'd0, 3'd2}, 1'b1, '{5'd1, 3'd2, 5'd19}},
        '{'{14'd1752, 4'd8, 3'd0, 3'd3}, 1'b1, '{5'd2, 3'd2, 5'd19}},
        '{'{14'd1752, 4'd8, 3'd0, 3'd4}, 1'b1, '{5'd14, 3'd2, 5'd19}},
        '{'{14'd1752, 4'd8, 3'd0, 3'd6}, 1'b1, '{5'd16, 3'd2, 5'd19}},
        '{'{14'd1752, 4'd8, 3'd2, 3'd6}, 1'b1, '{5'd30, 3'd2, 5'd19}},
        '{'{14'd1752, 4'd8, 3'd3, 3'd0}, 1'b1, '{5'd0, 3'd2, 5'd19}},
        '{'{14'd1752, 4'd8, 3'd5, 3'd6}, 1'b1, '{5'd0, 3'd2, 5'd19}},
        '{'{14'd1752, 4'd8, 3'd7, 3'd7}, 1'b1, '{5'd0, 3'd2, 5'd19}},
        '{'{14'd1752, 4'd8, 3'd6, 3'd0}, 1'b1, '{5'd0, 3'd2, 5'd19}},
        // range edges and saturation
        '{'{14'd0,     4'd0,  3'd0, 3'd0}, 1'b0, '0},
        '{'{14'd1,     4'd0,  3'd0, 3'd0}, 1'b0, '0},
        '{'{14'd1,     4'd1,  3'd4, 3'd6}, 1'b0, '0},
        '{'{14'd9999,  4'd11, 3'd5, 3'd6}, 1'b0, '0},
        '{'{14'd16383, 4'd15, 3'd7, 3'd7}, 1'b0, '0},
        '{'{14'd10000, 4'd12, 3'd0, 3'd1}, 1'b0, '0},
        // leap rules on both sides of the switch
        '{'{14'd1700, 4'd1, 3'd4, 3'd2}, 1'b0, '0},
        '{'{14'd1800, 4'd1, 3'd4, 3'd3}, 1'b0, '0},
        '{'{14'd1900, 4'd1, 3'd4, 3'd0}, 1'b0, '0},
        '{'{14'd2000, 4'd1, 3'd4, 3'd2}, 1'b0, '0},
        // months around the switch-over, plus one modern month
        '{'{14'd1752, 4'd7, 3'd4, 3'd6}, 1'b0, '0},
        '{'{14'd1752, 4'd9, 3'd0, 3'd0}, 1'b0, '0},
        '{'{14'd1753, 4'd0, 3'd0, 3'd0}, 1'b0, '0},
        '{'{14'd2024, 4'd3, 3'd0, 3'd6}, 1'b0, '0}
    };

    logic               i_clk;
    logic               i_rst_n;
    logic               start;
    logic               busy;
    logic [YEAR_W-1:0]  i_year;
    logic [MONTH_W-1:0] i_month;
    logic [ROW_W-1:0]   i_row;
    logic [COL_W-1:0]   i_column;
    logic               o_valid;
    logic [DAY_W-1:0]   o_day_number;
    logic [WDAY_W-1:0]  o_first_weekday;
    logic [DAY_W-1:0]   o_month_length;

    t_cell_view  due_cells [$];
    t_cell_view  due_view;
    t_cell_view  seen_view;
    int unsigned mismatch_count;
    int unsigned cycle_count;

    calendar_month_grid_cell dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_year          (i_year),
        .i_month         (i_month),
        .i_row           (i_row),
        .i_column        (i_column),
        .o_valid         (o_valid),
        .o_day_number    (o_day_number),
        .o_first_weekday (o_first_weekday),
        .o_month_length  (o_month_length)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Day shown in one grid cell, plus weekday of the 1st and month length.
    function automatic t_cell_view predict_cell(t_cell_req req);
        int unsigned yr, mo, row, col, a, y, m, wsum, first, len, k, pos, day;
        logic        leap;
        t_cell_view  v;
        yr  = req.year;
        mo  = req.month;
        row = req.row;
        col = req.column;
        day = 0;
        if (yr < YEAR_MIN) yr = YEAR_MIN;
        if (yr > YEAR_MAX) yr = YEAR_MAX;
        if (mo > MONTH_MAX) mo = MONTH_MAX;

        // March-based year: January and February count with the year before
        a = (13 - mo) / 12;
        y = yr - a;
        m = mo + 12 * a - 1;
        if (y > SWITCH_YEAR || (yr == SWITCH_YEAR && mo > SWITCH_MONTH)) begin
            wsum = 1 + y + y / 4 - y / 100 + y / 400 + (31 * m) / 12;
        end else begin
            wsum = 6 + y + y / 4 + (31 * m) / 12;
        end
        first = wsum % 7;

        if (yr == SWITCH_YEAR && mo == SWITCH_MONTH) begin
            // cells 2 and 3 hold the 1st and 2nd, cells 4..20 hold the 14th..30th
            len = SWITCH_LEN;
            k   = row * 7 + col;
            if (row <= ROW_MAX && col <= COL_MAX) begin
                if (k == 2) day = 1;
                else if (k == 3) day = 2;
                else if (k >= 4 && k <= 20) day = k + 10;
            end
        end else begin
            leap = (yr % 4 == 0) && (yr <= SWITCH_YEAR || yr % 100 != 0 || yr % 400 == 0);
            len  = MONTH_DAYS[mo] + ((mo == MONTH_FEB && leap) ? 1 : 0);
            if (row <= ROW_MAX && col <= COL_MAX) begin
                pos = 1 + row * 7 + col;
                if (pos > first && pos - first <= len) day = pos - first;
            end
        end
        v.day      = DAY_W'(day);
        v.first_wd = WDAY_W'(first);
        v.len      = DAY_W'(len);
        return v;
    endfunction

    function automatic t_cell_req random_cell();
        t_cell_req   req;
        int unsigned pick;
        pick       = $urandom_range(0, 99);
        req.year   = YEAR_W'($urandom_range(1, 9999));
        req.month  = MONTH_W'($urandom_range(0, 11));
        req.row    = ROW_W'($urandom_range(0, 5));
        req.column = COL_W'($urandom_range(0, 6));
        if (pick < 8) begin
            req.year  = SWITCH_YEAR;
            req.month = SWITCH_MONTH;
        end else if (pick < 20) begin
            req.year = YEAR_W'($urandom_range(1750, 1754));
        end else if (pick < 30) begin
            // Feb of century and quad years exercises the leap rules
            req.month = MONTH_FEB;
            req.year  = YEAR_W'($urandom_range(1, 99) * (($urandom_range(0, 1) == 1) ? 100 : 4));
        end else if (pick >= 90) begin
            req.year   = YEAR_W'($urandom);
            req.month  = MONTH_W'($urandom);
            req.row    = ROW_W'($urandom);
            req.column = COL_W'($urandom);
        end
        return req;
    endfunction

    // Drive one transaction, idling each cycle with the given odds, and log its expectation.
    task automatic send_cell(t_cell_req req, logic typed, t_cell_view want, int unsigned idle_pct);
        while (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
            start <= 1'b0;
            @(posedge i_clk);
        end
        i_year   <= req.year;
        i_month  <= req.month;
        i_row    <= req.row;
        i_column <= req.column;
        start    <= 1'b1;
        do @(posedge i_clk); while (busy);
        due_cells.push_back(typed ? want : predict_cell(req));
    endtask

    // Hold off until every outstanding transaction has come back.
    task automatic drain_cells();
        start <= 1'b0;
        do @(posedge i_clk); while (due_cells.size() != 0);
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            seen_view = '{o_day_number, o_first_weekday, o_month_length};
            if (due_cells.size() == 0) begin
                mismatch_count = mismatch_count + 1;
                if (mismatch_count <= MAX_REPORTS)
                    $display("unexpected cell: day %0d first %0d len %0d",
                             seen_view.day, seen_view.first_wd, seen_view.len);
            end else begin
                due_view = due_cells.pop_front();
                if (seen_view != due_view) begin
                    mismatch_count = mismatch_count + 1;
                    if (mismatch_count <= MAX_REPORTS)
                        $display("cell mismatch: day %0d/%0d first %0d/%0d len %0d/%0d",
                                 due_view.day, seen_view.day,
                                 due_view.first_wd, seen_view.first_wd,
                                 due_view.len, seen_view.len);
                end
            end
        end
    end

    initial begin
        int unsigned run_idle [3];
        run_idle       = '{18, 55, 0};
        mismatch_count = 0;
        cycle_count    = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_year         = '0;
        i_month        = '0;
        i_row          = '0;
        i_column       = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++)
            send_cell(GRID_TABLE[i].req, GRID_TABLE[i].typed, GRID_TABLE[i].want, 0);
        drain_cells();

        for (int run = 0; run < 3; run++) begin
            for (int i = 0; i < ITEMS_PER_RUN; i++)
                send_cell(random_cell(), 1'b0, '0, run_idle[run]);
            drain_cells();
        end

        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (due_cells.size() != 0)
            mismatch_count = mismatch_count + due_cells.size();

        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

[calendar_month_grid_cell.f]
design/cmg_pkg.sv
design/cmg_front.sv
design/cmg_sum.sv
design/cmg_mod7.sv
design/cmg_cell.sv
design/calendar_month_grid_cell.sv
bench/calendar_month_grid_cell_tb.sv
